FILE: hdl/gsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsm_pkg: shared types and constants for the grid shape matcher
// Class codes, the shape ROM and the sequencer control bundle.
// ----------------------------------------------------------------------------
package gsm_pkg;

	localparam int NodeCount    = 16;
	localparam int PatternCount = 100;
	localparam int NodeIdxW     = $clog2(NodeCount);
	localparam int PatIdxW      = $clog2(PatternCount);
	localparam int CountW       = $clog2(NodeCount + 1);
	localparam int ClassW       = 5;
	localparam int AgeW         = 8;

	localparam logic [ClassW-1:0] CLS_NONE     = 5'h00;
	localparam logic [ClassW-1:0] CLS_SQUARE   = 5'h01;
	localparam logic [ClassW-1:0] CLS_TRIANGLE = 5'h02;
	localparam logic [ClassW-1:0] CLS_HRECT    = 5'h04;
	localparam logic [ClassW-1:0] CLS_VRECT    = 5'h08;
	localparam logic [ClassW-1:0] CLS_PLUS     = 5'h10;

	localparam logic [AgeW-1:0] AGE_LIMIT_RST = 8'd25;

	localparam logic OP_MERGE    = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;

	localparam logic [PatIdxW-1:0] LAST_PATTERN = PatIdxW'(PatternCount - 1);
	localparam logic [PatIdxW-1:0] LAST_NODE    = PatIdxW'(NodeCount - 1);

	localparam logic [NodeCount-1:0] SHAPE_ROM [PatternCount] = '{
		// squares
		16'h0033, 16'h0066, 16'h00CC, 16'h0330, 16'h0660, 16'h0CC0, 16'h3300,
		16'h6600, 16'hCC00, 16'h0777, 16'h0EEE, 16'h7770, 16'hEEE0, 16'hFFFF,
		// triangles
		16'h0013, 16'h0032, 16'h0031, 16'h0023, 16'h0026, 16'h0046, 16'h0064,
		16'h0062, 16'h004C, 16'h008C, 16'h00C8, 16'h00C4, 16'h0130, 16'h0230,
		16'h0310, 16'h0320, 16'h0260, 16'h0460, 16'h0620, 16'h0640, 16'h04C0,
		16'h08C0, 16'h0C40, 16'h0C80, 16'h1300, 16'h2300, 16'h3100, 16'h3200,
		16'h2600, 16'h4600, 16'h6200, 16'h6400, 16'h4C00, 16'h8C00, 16'hC400,
		16'hC800,
		// plus
		16'h0272, 16'h04E4, 16'h2720, 16'h4E40,
		// vrect
		16'h0007, 16'h000E, 16'h0070, 16'h00E0, 16'h0700, 16'h0E00, 16'h7000,
		16'hE000, 16'h0077, 16'h00EE, 16'h0770, 16'h0EE0, 16'h7700, 16'hEE00,
		16'h000F, 16'h00F0, 16'h0F00, 16'hF000, 16'h00FF, 16'h0FF0, 16'hFF00,
		16'h0FFF, 16'hFFF0,
		// hrect
		16'h0111, 16'h0222, 16'h0444, 16'h0888, 16'h1110, 16'h2220, 16'h4440,
		16'h8880, 16'h0333, 16'h0666, 16'h0CCC, 16'h3330, 16'h6660, 16'hCCC0,
		16'h1111, 16'h2222, 16'h4444, 16'h8888, 16'h3333, 16'h6666, 16'hCCCC,
		16'h7777, 16'hEEEE
	};

	typedef struct packed {
		logic               node_step;
		logic               scan_clear;
		logic               scan_step;
		logic [PatIdxW-1:0] index;
	} gsm_ctrl_t;

	function automatic logic [ClassW-1:0] class_of(input logic [PatIdxW-1:0] k);
		logic [ClassW-1:0] cls;
		if (k < PatIdxW'(14))      cls = CLS_SQUARE;
		else if (k < PatIdxW'(50)) cls = CLS_TRIANGLE;
		else if (k < PatIdxW'(54)) cls = CLS_PLUS;
		else if (k < PatIdxW'(77)) cls = CLS_VRECT;
		else                       cls = CLS_HRECT;
		return cls;
	endfunction

endpackage

FILE: hdl/gsm_node_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsm_node_unit: node state and shared age update unit
// Holds coverage, known bits and ages; updates one node per step.
// ----------------------------------------------------------------------------
module gsm_node_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gsm_pkg::gsm_ctrl_t                  ctrl,
	input  logic [gsm_pkg::AgeW-1:0]            age_limit,
	input  logic [gsm_pkg::NodeCount-1:0]       covered_bits,
	input  logic [gsm_pkg::NodeCount-1:0]       heard_bits,
	output logic [gsm_pkg::NodeCount-1:0]       coverage,
	output logic [gsm_pkg::NodeCount-1:0]       known
);

	logic [gsm_pkg::AgeW-1:0]      age_q [gsm_pkg::NodeCount];
	logic [gsm_pkg::NodeCount-1:0] cov_q;
	logic [gsm_pkg::NodeCount-1:0] known_q;
	logic [gsm_pkg::NodeIdxW-1:0]  node;
	logic [gsm_pkg::AgeW-1:0]      age_cur;

	assign node    = ctrl.index[gsm_pkg::NodeIdxW-1:0];
	assign age_cur = age_q[node];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cov_q   <= '0;
			known_q <= '0;
			for (int i = 0; i < gsm_pkg::NodeCount; i++) begin
				age_q[i] <= '0;
			end
		end else if (ctrl.node_step) begin
			if (heard_bits[node]) begin
				cov_q[node]   <= covered_bits[node];
				known_q[node] <= 1'b1;
				age_q[node]   <= age_limit;
			end else if (age_cur == gsm_pkg::AgeW'(1)) begin
				cov_q[node]   <= 1'b0;
				known_q[node] <= 1'b0;
				age_q[node]   <= '0;
			end else if (age_cur != '0) begin
				age_q[node]   <= age_cur - gsm_pkg::AgeW'(1);
			end
		end
	end

	assign coverage = cov_q;
	assign known    = known_q;

endmodule

FILE: hdl/gsm_shape_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsm_shape_scan: shape ROM scanner
// Compares one ROM entry per step; counts known nodes on the first steps.
// ----------------------------------------------------------------------------
module gsm_shape_scan (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gsm_pkg::gsm_ctrl_t                  ctrl,
	input  logic [gsm_pkg::NodeCount-1:0]       coverage,
	input  logic [gsm_pkg::NodeCount-1:0]       known,
	output logic [gsm_pkg::ClassW-1:0]          shape_found,
	output logic [gsm_pkg::ClassW-1:0]          shape_guesses
);

	logic [gsm_pkg::ClassW-1:0]    found_q;
	logic [gsm_pkg::ClassW-1:0]    cand_q;
	logic [gsm_pkg::CountW-1:0]    nknown_q;
	logic [gsm_pkg::NodeCount-1:0] pattern;
	logic [gsm_pkg::ClassW-1:0]    cls;
	logic [gsm_pkg::ClassW-1:0]    allowed;

	assign pattern = gsm_pkg::SHAPE_ROM[ctrl.index];
	assign cls     = gsm_pkg::class_of(ctrl.index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= gsm_pkg::CLS_NONE;
			cand_q   <= '0;
			nknown_q <= '0;
		end else if (ctrl.scan_clear) begin
			found_q  <= gsm_pkg::CLS_NONE;
			cand_q   <= '0;
			nknown_q <= '0;
		end else if (ctrl.scan_step) begin
			if (pattern == coverage) begin
				found_q <= cls;
			end
			if ((pattern & known) == coverage) begin
				cand_q <= cand_q | cls;
			end
			if (ctrl.index < gsm_pkg::PatIdxW'(gsm_pkg::NodeCount)) begin
				nknown_q <= nknown_q
					+ gsm_pkg::CountW'(known[ctrl.index[gsm_pkg::NodeIdxW-1:0]]);
			end
		end
	end

	always_comb begin
		allowed = '0;
		if (nknown_q >= gsm_pkg::CountW'(2)) begin
			allowed = gsm_pkg::CLS_TRIANGLE | gsm_pkg::CLS_HRECT | gsm_pkg::CLS_VRECT;
		end
		if (nknown_q >= gsm_pkg::CountW'(3)) begin
			allowed = allowed | gsm_pkg::CLS_SQUARE | gsm_pkg::CLS_PLUS;
		end
	end

	assign shape_found   = found_q;
	assign shape_guesses = cand_q & ~found_q & allowed;

endmodule

FILE: hdl/grid_shape_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_shape_matcher: 4x4 node grid tracker and shape classifier
// Merges coverage reports with per-node aging and classifies the grid.
// ----------------------------------------------------------------------------
// One request at a time. A merge request (tuser 0) walks the 16 nodes through
// the shared age unit, one node per cycle; a classify request (tuser 1) walks
// the 100-entry shape ROM one entry per cycle. s_tready is high only while no
// request is in work; a finished result waits in the output register without
// blocking the next accept. The user must write age_limit through cfg_we and
// cfg_wdata only while idle; the block itself does not enforce this.
module grid_shape_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // covered_bits[15:0], heard_bits[31:16]
	input  logic        s_tuser,   // opcode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // shape_found[4:0], shape_guesses[9:5],
	                               // covered_now[25:10], known_now[41:26], zero
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MERGE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t                          state_q;
	logic [gsm_pkg::PatIdxW-1:0]     cnt_q;
	logic                            op_q;
	logic [gsm_pkg::NodeCount-1:0]   covered_q;
	logic [gsm_pkg::NodeCount-1:0]   heard_q;
	logic [gsm_pkg::AgeW-1:0]        age_limit_q;
	logic                            out_valid_q;
	logic [47:0]                     out_data_q;

	gsm_pkg::gsm_ctrl_t              ctrl;
	logic                            accept;
	logic [gsm_pkg::NodeCount-1:0]   coverage;
	logic [gsm_pkg::NodeCount-1:0]   known;
	logic [gsm_pkg::ClassW-1:0]      found;
	logic [gsm_pkg::ClassW-1:0]      guesses;
	logic [gsm_pkg::ClassW-1:0]      res_found;
	logic [gsm_pkg::ClassW-1:0]      res_guesses;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		ctrl.node_step  = (state_q == ST_MERGE);
		ctrl.scan_step  = (state_q == ST_SCAN);
		ctrl.scan_clear = accept;
		ctrl.index      = cnt_q;
	end

	gsm_node_unit u_node (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.age_limit    (age_limit_q),
		.covered_bits (covered_q),
		.heard_bits   (heard_q),
		.coverage     (coverage),
		.known        (known)
	);

	gsm_shape_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.coverage      (coverage),
		.known         (known),
		.shape_found   (found),
		.shape_guesses (guesses)
	);

	assign res_found   = (op_q == gsm_pkg::OP_CLASSIFY) ? found : gsm_pkg::CLS_NONE;
	assign res_guesses = (op_q == gsm_pkg::OP_CLASSIFY) ? guesses : gsm_pkg::CLS_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q <= gsm_pkg::AGE_LIMIT_RST;
		end else if (cfg_we) begin
			age_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= s_tuser;
			covered_q <= s_tdata[15:0];
			heard_q   <= s_tdata[31:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_valid_q && m_tready && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= (s_tuser == gsm_pkg::OP_CLASSIFY) ? ST_SCAN : ST_MERGE;
					end
				end
				ST_MERGE: begin
					if (cnt_q == gsm_pkg::LAST_NODE) begin
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q + gsm_pkg::PatIdxW'(1);
					end
				end
				ST_SCAN: begin
					if (cnt_q == gsm_pkg::LAST_PATTERN) begin
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q + gsm_pkg::PatIdxW'(1);
					end
				end
				ST_EMIT: begin
					// hold until the output register is free
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {6'd0, known, coverage, res_guesses, res_found};
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: hdl/gsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsm_checker: port-level checks for the grid shape matcher
// Watches the stream ports and the result fields over time.
// ----------------------------------------------------------------------------
module gsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a request while busy");

	a_found_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[4:0]))
		else $error("more than one exact class");

	a_guess_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[9:5] & m_tdata[4:0]) == 5'd0)
		else $error("guess repeats the exact class");

	a_cov_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[25:10] & ~m_tdata[41:26]) == 16'd0)
		else $error("covered node not known");

endmodule

bind grid_shape_matcher gsm_checker u_gsm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
